// ===== rtl/core/acbf_pkg.sv =====
// Package for the autocrop bounds finder: sizes, register indexes and
// small helper functions. No dependencies.
package acbf_pkg;

  localparam int MAX_DIM = 4096;
  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int CNT_W   = $clog2(MAX_DIM);
  localparam int CFG_W   = 13;
  localparam int TRIM_W  = 13;
  localparam int PIX_W   = 24;
  localparam int CH_W    = 8;
  localparam int IDX_W   = 2;
  localparam int IN_DW   = 24;
  localparam int OUT_DW  = 56;

  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_COLOR_MODE   = 2'd2;

  typedef logic [DIM_W-1:0]  dim_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [TRIM_W-1:0] trim_t;

  // Zero is treated as one, anything above MAX_DIM as MAX_DIM.
  function automatic dim_t clamp_dim(input logic [CFG_W-1:0] v);
    dim_t r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > 32'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

  function automatic trim_t trim_of(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[TRIM_W-1:0];
  endfunction

endpackage

// ===== rtl/core/autocrop_bounds_finder.sv =====
// Autocrop bounds finder top level: background latch, bounding box tracking
// and result register. Depends on acbf_pkg.
//
// Channel   Dir  Payload (low bit first)
// in_       in   tdata: chan_zero[7:0], chan_one[15:8], chan_two[23:16]
// out_      out  tdata: left_trim, right_trim, top_trim, bottom_trim, found_any
// cfg_      in   cfg_index selects frame_width / frame_height / color_mode
//
// One pixel per cycle while in_tready is high; the compare and min/max update sit
// between the input handshake and the state and result registers, so the result of
// a frame's last pixel appears in the cycle after its transfer.
// Reset (rst_n low, synchronous) clears counters, bounds and the result valid, and restores the config registers.
// in_tready drops only when the next pixel closes a frame and the previous
// result is still stalled on out_.
module autocrop_bounds_finder
  import acbf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // chan_zero, chan_one, chan_two
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // left, right, top, bottom trims, found_any, pad
  input  logic              cfg_wr_en,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  dim_t              w_r, h_r;
  logic              mode_r;
  logic [PIX_W-1:0]  bg_r;
  cnt_t              col_r, row_r;
  dim_t              lo_col_r, lo_row_r;
  cnt_t              hi_col_r, hi_row_r;
  logic              seen_r;
  logic              out_valid_r;
  logic [OUT_DW-1:0] out_data_r;

  logic              take;
  logic              start;
  logic              row_end, frame_end;
  logic [PIX_W-1:0]  pix, bg_eff, cmp_mask;
  logic              differs;
  dim_t              lo_col_nxt, lo_row_nxt;
  cnt_t              hi_col_nxt, hi_row_nxt;
  logic              seen_nxt;
  logic [OUT_DW-1:0] out_data_nxt;

  assign pix       = in_tdata[PIX_W-1:0];
  assign start     = (col_r == '0) && (row_r == '0);
  assign row_end   = (DIM_W'(col_r) + DIM_W'(1)) >= w_r;
  assign frame_end = row_end && ((DIM_W'(row_r) + DIM_W'(1)) >= h_r);
  assign in_tready = !(out_valid_r && !out_tready && frame_end);
  assign take      = in_tvalid && in_tready;

  assign bg_eff   = start ? pix : bg_r;
  assign cmp_mask = mode_r ? {PIX_W{1'b1}} : PIX_W'({CH_W{1'b1}});
  assign differs  = ((pix ^ bg_eff) & cmp_mask) != '0;

  always_comb begin
    lo_col_nxt = start ? w_r : lo_col_r;
    lo_row_nxt = start ? h_r : lo_row_r;
    hi_col_nxt = start ? '0 : hi_col_r;
    hi_row_nxt = start ? '0 : hi_row_r;
    seen_nxt   = start ? 1'b0 : seen_r;
    if (differs) begin
      if (DIM_W'(col_r) < lo_col_nxt) lo_col_nxt = DIM_W'(col_r);
      if (col_r > hi_col_nxt)         hi_col_nxt = col_r;
      if (DIM_W'(row_r) < lo_row_nxt) lo_row_nxt = DIM_W'(row_r);
      if (row_r > hi_row_nxt)         hi_row_nxt = row_r;
      seen_nxt = 1'b1;
    end
    out_data_nxt = '0;
    out_data_nxt[TRIM_W-1:0]          = trim_of(32'd0, 32'(lo_col_nxt));
    out_data_nxt[2*TRIM_W-1:TRIM_W]   = trim_of(32'(hi_col_nxt), 32'(w_r));
    out_data_nxt[3*TRIM_W-1:2*TRIM_W] = trim_of(32'd0, 32'(lo_row_nxt));
    out_data_nxt[4*TRIM_W-1:3*TRIM_W] = trim_of(32'(hi_row_nxt), 32'(h_r));
    out_data_nxt[4*TRIM_W]            = seen_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r    <= DIM_W'(MAX_DIM);
      h_r    <= DIM_W'(MAX_DIM);
      mode_r <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  w_r    <= clamp_dim(cfg_wdata);
        REG_FRAME_HEIGHT: h_r    <= clamp_dim(cfg_wdata);
        REG_COLOR_MODE:   mode_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bg_r     <= '0;
      col_r    <= '0;
      row_r    <= '0;
      lo_col_r <= DIM_W'(MAX_DIM);
      lo_row_r <= DIM_W'(MAX_DIM);
      hi_col_r <= '0;
      hi_row_r <= '0;
      seen_r   <= 1'b0;
    end else if (take) begin
      bg_r     <= bg_eff;
      lo_col_r <= lo_col_nxt;
      lo_row_r <= lo_row_nxt;
      hi_col_r <= hi_col_nxt;
      hi_row_r <= hi_row_nxt;
      seen_r   <= seen_nxt;
      if (frame_end) begin
        col_r <= '0;
        row_r <= '0;
      end else if (row_end) begin
        col_r <= '0;
        row_r <= row_r + CNT_W'(1);
      end else begin
        col_r <= col_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take && frame_end) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && frame_end) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/core/acbf_port_checker.sv =====
// Port-level checks for autocrop_bounds_finder, attached by bind.
// Depends on acbf_pkg.
module acbf_port_checker
  import acbf_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_DW-1:0] out_tdata
);

  logic  found;
  trim_t left_t, right_t, top_t, bottom_t;

  assign left_t   = out_tdata[TRIM_W-1:0];
  assign right_t  = out_tdata[2*TRIM_W-1:TRIM_W];
  assign top_t    = out_tdata[3*TRIM_W-1:2*TRIM_W];
  assign bottom_t = out_tdata[4*TRIM_W-1:3*TRIM_W];
  assign found    = out_tdata[4*TRIM_W];

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  // untouched low bounds equal the frame size, at least one, so an empty frame never trims by zero
  a_empty_cols: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !found |-> (left_t != '0) && (right_t != '0))
    else $error("empty frame with a zero column trim");

  a_empty_rows: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !found |-> (top_t != '0) && (bottom_t != '0))
    else $error("empty frame with a zero row trim");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind autocrop_bounds_finder acbf_port_checker u_acbf_port_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== tb/acbf_checker.sv =====
// Checker for the autocrop bounds finder: watches the pixel, result and register
// ports, predicts each frame's crop trims and compares them field by field.
// Depends on acbf_pkg.
module acbf_checker
  import acbf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [OUT_DW-1:0] out_tdata,
  input  logic              cfg_wr_en,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  output int                fail_count,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    trim_t left;
    trim_t right;
    trim_t top;
    trim_t bottom;
    logic  found;
  } crop_t;

  crop_t crop_q[$];

  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  logic             gray_n;
  logic [PIX_W-1:0] bg_color;
  int               col;
  int               row;
  int               lo_col;
  int               hi_col;
  int               lo_row;
  int               hi_row;
  bit               seen;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic int usable_dim(input logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    fail_count++;
    if (fail_count <= 100)
      $display("%0t ns: %s got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic track_pixel(input logic [PIX_W-1:0] pix);
    int               w;
    int               h;
    logic [PIX_W-1:0] mask;
    crop_t            c;
    w = usable_dim(width_reg);
    h = usable_dim(height_reg);
    if (col == 0 && row == 0) begin
      bg_color = pix;
      lo_col = w;
      hi_col = 0;
      lo_row = h;
      hi_row = 0;
      seen = 1'b0;
    end
    mask = gray_n ? 24'hFF_FFFF : 24'h00_00FF;
    if (((pix ^ bg_color) & mask) != '0) begin
      if (col < lo_col) lo_col = col;
      if (col > hi_col) hi_col = col;
      if (row < lo_row) lo_row = row;
      if (row > hi_row) hi_row = row;
      seen = 1'b1;
    end
    if (col + 1 >= w) begin
      if (row + 1 >= h) begin
        c.left   = trim_t'(-lo_col);
        c.right  = trim_t'(hi_col - w);
        c.top    = trim_t'(-lo_row);
        c.bottom = trim_t'(hi_row - h);
        c.found  = seen;
        crop_q = {crop_q, c};
        col = 0;
        row = 0;
      end else begin
        col = 0;
        row++;
      end
    end else begin
      col++;
    end
  endtask

  task automatic check_crop(input logic [OUT_DW-1:0] d);
    crop_t c;
    trim_t f;
    if (crop_q.size() == 0) begin
      report_mismatch("unexpected result transfer, left_trim", int'($signed(d[TRIM_W-1:0])), 0);
    end else begin
      c = crop_q.pop_front();
      f = d[TRIM_W-1:0];
      if (f !== c.left) report_mismatch("left_trim", int'($signed(f)), int'($signed(c.left)));
      f = d[2*TRIM_W-1:TRIM_W];
      if (f !== c.right) report_mismatch("right_trim", int'($signed(f)), int'($signed(c.right)));
      f = d[3*TRIM_W-1:2*TRIM_W];
      if (f !== c.top) report_mismatch("top_trim", int'($signed(f)), int'($signed(c.top)));
      f = d[4*TRIM_W-1:3*TRIM_W];
      if (f !== c.bottom)
        report_mismatch("bottom_trim", int'($signed(f)), int'($signed(c.bottom)));
      if (d[4*TRIM_W] !== c.found)
        report_mismatch("found_any", int'(d[4*TRIM_W]), int'(c.found));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg = CFG_W'(MAX_DIM);
      height_reg = CFG_W'(MAX_DIM);
      gray_n = 1'b1;
      bg_color = '0;
      col = 0;
      row = 0;
      lo_col = MAX_DIM;
      hi_col = 0;
      lo_row = MAX_DIM;
      hi_row = 0;
      seen = 1'b0;
      crop_q.delete();
    end else begin
      if (in_tvalid && in_tready) track_pixel(in_tdata);
      if (out_tvalid && out_tready) check_crop(out_tdata);
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  width_reg = cfg_wdata;
          REG_FRAME_HEIGHT: height_reg = cfg_wdata;
          REG_COLOR_MODE:   gray_n = cfg_wdata[0];
          default: ;
        endcase
      end
    end
    pending = crop_q.size();
  end

endmodule

// ===== tb/tb.sv =====
// Top of the autocrop bounds finder testbench: clock, reset, pixel and register
// stimulus, output stalls and the verdict. Depends on acbf_pkg, acbf_checker and
// the block itself.
module tb
  import acbf_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_DW-1:0] out_tdata;
  logic              cfg_wr_en = 1'b0;
  logic [IDX_W-1:0]  cfg_index = REG_FRAME_WIDTH;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  int                fail_count;
  int                pending;

  bit                steady_flow = 1'b0;
  logic [CFG_W-1:0]  cur_w;
  logic [CFG_W-1:0]  cur_h;
  int                small_items = 0;

  autocrop_bounds_finder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  acbf_checker crop_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("autocrop_bounds_finder: mismatch");
    $finish;
  end

  always @(posedge clk) begin
    out_tready <= steady_flow || ($urandom_range(99) >= 35);
  end

  function automatic int frame_dim(input logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  // background pixel, or one that differs with the given per-mille odds
  function automatic logic [PIX_W-1:0] pick_pixel(input logic [PIX_W-1:0] bg,
                                                  input int permille);
    logic [PIX_W-1:0] pix;
    pix = bg;
    if ($urandom_range(999) < permille) begin
      case ($urandom_range(3))
        0:       pix = bg ^ {16'h0, 8'($urandom_range(255, 1))};
        1:       pix = bg ^ {8'h0, 8'($urandom_range(255, 1)), 8'h0};
        2:       pix = bg ^ {8'($urandom_range(255, 1)), 16'h0};
        default: pix = PIX_W'($urandom);
      endcase
    end
    return pix;
  endfunction

  task automatic push_pixel(input logic [PIX_W-1:0] pix);
    while (!steady_flow && $urandom_range(99) < 35) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= pix;
    do @(posedge clk); while (!in_tready);
  endtask

  // drain, let the last frame settle, then write all three registers
  task automatic set_config(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                            input logic m);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_index <= REG_COLOR_MODE;
    cfg_wdata <= CFG_W'(m);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_w = w;
    cur_h = h;
  endtask

  // first pixel is the background; the rest differ with the given per-mille odds
  task automatic send_frame(input int permille);
    int               n;
    logic [PIX_W-1:0] bg;
    n = frame_dim(cur_w) * frame_dim(cur_h);
    bg = PIX_W'($urandom);
    push_pixel(bg);
    for (int i = 1; i < n; i++) begin
      push_pixel(pick_pixel(bg, permille));
    end
    small_items += n;
  endtask

  // frame started at a large size, closed early by shrinking its long side
  task automatic send_cut_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                                input logic m, input int count, input int permille);
    logic [PIX_W-1:0] bg;
    set_config(w, h, m);
    bg = PIX_W'($urandom);
    push_pixel(bg);
    for (int i = 1; i < count; i++) begin
      push_pixel(pick_pixel(bg, permille));
    end
    if (frame_dim(w) > 1) begin
      set_config(CFG_W'(count + 1), h, m);
    end else begin
      set_config(w, CFG_W'(count + 1), m);
    end
    push_pixel(pick_pixel(bg, permille));
    small_items += count + 1;
  endtask

  initial begin
    int               phase;
    int               frames;
    int               density;
    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] h;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single pixel frames: nothing can differ
    set_config(13'd1, 13'd1, 1'b1);
    push_pixel(24'h000000);
    push_pixel(24'hFFFFFF);
    // color mode, only the second and third channels differ
    set_config(13'd3, 13'd2, 1'b1);
    push_pixel(24'h123456);
    push_pixel(24'h923456);
    push_pixel(24'h123456);
    push_pixel(24'h123456);
    push_pixel(24'h12B456);
    push_pixel(24'h123456);
    // gray mode ignores the upper channels
    set_config(13'd3, 13'd2, 1'b0);
    push_pixel(24'hAB00FF);
    push_pixel(24'h0000FF);
    push_pixel(24'hABFFFF);
    push_pixel(24'hFF00FF);
    push_pixel(24'h5555FF);
    push_pixel(24'hAB00FF);
    // zero sizes behave as one
    set_config(13'd0, 13'd0, 1'b0);
    push_pixel(24'hFFFFFF);
    // difference only in the last column
    set_config(13'd4, 13'd1, 1'b0);
    push_pixel(24'h0000FF);
    push_pixel(24'hFF00FF);
    push_pixel(24'h00FFFF);
    push_pixel(24'h000000);
    small_items = 0;

    phase = 0;
    while (small_items < 730 || phase < 14) begin
      steady_flow = (phase >= 3 && phase <= 6);
      case (phase)
        2: begin
          send_cut_frame(13'd4096, 13'd1, 1'b1, 40, 3);
        end
        5: begin
          send_cut_frame(13'd1, 13'd4096, 1'b0, 40, 3);
        end
        9: begin
          send_cut_frame(13'd8191, 13'd1, 1'b0, 40, 0);
        end
        13: begin
          send_cut_frame(13'd1, 13'd8191, 1'b1, 40, 0);
        end
        default: begin
          case ($urandom_range(9))
            0:       w = 13'd0;
            1:       w = 13'd1;
            default: w = CFG_W'($urandom_range(8, 2));
          endcase
          case ($urandom_range(9))
            0:       h = 13'd0;
            1:       h = 13'd1;
            default: h = CFG_W'($urandom_range(6, 2));
          endcase
          set_config(w, h, 1'($urandom_range(1)));
          frames = $urandom_range(6, 1);
          repeat (frames) begin
            case ($urandom_range(3))
              0:       density = 0;
              1:       density = 30;
              2:       density = 250;
              default: density = 800;
            endcase
            send_frame(density);
          end
        end
      endcase
      phase++;
    end
    steady_flow = 1'b0;

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("autocrop_bounds_finder: match");
    end else begin
      $display("autocrop_bounds_finder: mismatch");
    end
    $finish;
  end

endmodule
